// ----- rtl/core/dprt_pkg.sv -----
// types and constants shared by the dirty page range tracker
`timescale 1ns / 1ps

package dprt_pkg;

    localparam int ADDR_W   = 48;
    localparam int WIDX_W   = 7;
    localparam int PAGE_SH  = 12;
    localparam int WORD_SH  = 17;
    localparam int BITS_W   = 32;
    localparam int MOD_STEP = 4;

    localparam logic CMD_MARK    = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;
    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_RANGE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] target_addr;
        logic [WIDX_W-1:0] word_index;
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] first_addr;
        logic [ADDR_W-1:0] end_addr;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_MARK_RD,
        S_MARK_WR,
        S_FLUSH_LD,
        S_FLUSH_SCAN
    } state_t;

endpackage

// ----- rtl/core/dirty_page_range_tracker_core.sv -----
// dirty page bitmap with write windows and coalesced flush ranges
`timescale 1ns / 1ps

// Command channel: request is taken at a clock edge with start high and busy
// low. A mark sets the bit of the 4 KiB page that holds target_addr and, if
// the page was clean, returns one write window (start, start + 4096). A flush
// clears bitmap word word_index and returns one range per run of set bits
// it held, with an inclusive end; an out-of-range word is ignored.
// Results come out on result with result_valid high for exactly one cycle
// each; last marks the final beat of an item. The receiver cannot stall.
// cache_base must be written through cfg_we / cfg_data only while the block
// is idle; the block itself does not enforce this. Timing: the bitmap sits
// in one synchronous RAM, one word per read-modify-write. When PAGE_WORDS is
// not a power of two the word number is first reduced by a 4-bit-per-cycle
// remainder unit. A flush reads the word and clears it in the RAM, then scans
// its bits from bit 0 up to the end of the last run, or stops at once for an
// empty word. Result beats are registered, driven the cycle after the mark
// write or the scan step that makes them. After reset the RAM is swept to
// zero, one word per cycle, with busy held high until the sweep is done.
module dirty_page_range_tracker_core #(
    parameter int PAGE_WORDS = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  dprt_pkg::req_t             request,
    input  logic                       cfg_we,
    input  logic [dprt_pkg::ADDR_W-1:0] cfg_data,
    output logic                       result_valid,
    output dprt_pkg::res_t             result
);

    localparam int WW = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam int RW = WW + 1;
    localparam int HI_W = dprt_pkg::ADDR_W - dprt_pkg::PAGE_SH;
    localparam int DIV_W = 32;
    localparam int MCNT_W = $clog2(DIV_W / dprt_pkg::MOD_STEP);
    localparam bit POW2 = ((PAGE_WORDS & (PAGE_WORDS - 1)) == 0);
    localparam logic [WW-1:0] IDX_MASK = WW'(PAGE_WORDS - 1);
    localparam logic [WW-1:0] IDX_LAST = WW'(PAGE_WORDS - 1);
    localparam logic [RW-1:0] DIVISOR = RW'(PAGE_WORDS);
    localparam logic [10:0] PW_L = 11'(PAGE_WORDS);

    dprt_pkg::state_t state_reg, state_next;

    logic [HI_W-1:0]              base_reg, base_next;
    logic [HI_W-1:0]              page_reg, page_next;
    logic [4:0]                   bit_reg, bit_next;
    logic [WW-1:0]                idx_reg, idx_next;
    logic [DIV_W-1:0]             div_reg, div_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [MCNT_W-1:0]            mcnt_reg, mcnt_next;
    logic [dprt_pkg::ADDR_W-1:0]  word_addr_reg, word_addr_next;
    logic [dprt_pkg::ADDR_W-1:0]  word_m1_reg, word_m1_next;
    logic [dprt_pkg::BITS_W-1:0]  sh_reg, sh_next;
    logic [4:0]                   j_reg, j_next;
    logic                         in_run_reg, in_run_next;
    logic [4:0]                   run_first_reg, run_first_next;
    logic [WW-1:0]                clr_reg, clr_next;
    logic                         res_valid_reg, res_valid_next;
    dprt_pkg::res_t               res_reg, res_next;

    logic [dprt_pkg::BITS_W-1:0]  mem [PAGE_WORDS];
    logic [dprt_pkg::BITS_W-1:0]  rd_data_reg;
    logic                         mem_re;
    logic                         mem_we;
    logic [WW-1:0]                mem_raddr;
    logic [WW-1:0]                mem_waddr;
    logic [dprt_pkg::BITS_W-1:0]  mem_wdata;

    logic [dprt_pkg::ADDR_W-1:0]  base_full;
    logic [dprt_pkg::ADDR_W-1:0]  offset;
    logic [WW-1:0]                flush_idx;
    logic                         flush_ok;
    logic [RW-1:0]                rem_w;
    logic [DIV_W-1:0]             div_w;
    logic [4:0]                   first_bit;
    logic [5:0]                   run_end;

    assign busy         = (state_reg != dprt_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign base_full = {base_reg, {dprt_pkg::PAGE_SH{1'b0}}};
    assign offset    = request.target_addr - base_full;
    assign flush_idx = WW'(request.word_index);
    assign flush_ok  = (11'(request.word_index) < PW_L);
    assign first_bit = in_run_reg ? run_first_reg : j_reg;
    assign run_end   = {1'b0, j_reg} + 6'd1;

    // remainder unit, a few dividend bits per cycle
    always_comb
    begin
        rem_w = rem_reg;
        div_w = div_reg;
        for (int k = 0; k < dprt_pkg::MOD_STEP; k++)
        begin
            rem_w = {rem_w[RW-2:0], div_w[DIV_W-1]};
            div_w = {div_w[DIV_W-2:0], 1'b0};
            if (rem_w >= DIVISOR)
            begin
                rem_w = rem_w - DIVISOR;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = cfg_we ? cfg_data[dprt_pkg::ADDR_W-1:dprt_pkg::PAGE_SH] : base_reg;
        page_next      = page_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        mcnt_next      = mcnt_reg;
        word_addr_next = word_addr_reg;
        word_m1_next   = word_m1_reg;
        sh_next        = sh_reg;
        j_next         = j_reg;
        in_run_next    = in_run_reg;
        run_first_next = run_first_reg;
        clr_next       = clr_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;

        case (state_reg)
            dprt_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + WW'(1);
                if (clr_reg == IDX_LAST)
                begin
                    state_next = dprt_pkg::S_IDLE;
                end
            end
            dprt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (request.command)
                        dprt_pkg::CMD_MARK:
                        begin
                            page_next = request.target_addr[dprt_pkg::ADDR_W-1:dprt_pkg::PAGE_SH];
                            bit_next  = offset[dprt_pkg::WORD_SH-1:dprt_pkg::PAGE_SH];
                            if (POW2)
                            begin
                                idx_next   = WW'(offset >> dprt_pkg::WORD_SH) & IDX_MASK;
                                mem_re     = 1'b1;
                                mem_raddr  = idx_next;
                                state_next = dprt_pkg::S_MARK_WR;
                            end
                            else
                            begin
                                div_next   = {1'b0, offset[dprt_pkg::ADDR_W-1:dprt_pkg::WORD_SH]};
                                rem_next   = '0;
                                mcnt_next  = '0;
                                state_next = dprt_pkg::S_MOD;
                            end
                        end
                        dprt_pkg::CMD_FLUSH:
                        begin
                            if (flush_ok)
                            begin
                                idx_next       = flush_idx;
                                mem_re         = 1'b1;
                                mem_raddr      = flush_idx;
                                word_addr_next = base_full
                                    + (dprt_pkg::ADDR_W'(request.word_index) << dprt_pkg::WORD_SH);
                                state_next     = dprt_pkg::S_FLUSH_LD;
                            end
                        end
                        default:
                        begin
                            state_next = dprt_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dprt_pkg::S_MOD:
            begin
                rem_next  = rem_w;
                div_next  = div_w;
                mcnt_next = mcnt_reg + MCNT_W'(1);
                if (mcnt_reg == '1)
                begin
                    idx_next   = rem_w[WW-1:0];
                    state_next = dprt_pkg::S_MARK_RD;
                end
            end
            dprt_pkg::S_MARK_RD:
            begin
                mem_re     = 1'b1;
                state_next = dprt_pkg::S_MARK_WR;
            end
            dprt_pkg::S_MARK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg | (32'd1 << bit_reg);
                if (!rd_data_reg[bit_reg])
                begin
                    res_valid_next      = 1'b1;
                    res_next.kind       = dprt_pkg::KIND_WINDOW;
                    res_next.first_addr = {page_reg, {dprt_pkg::PAGE_SH{1'b0}}};
                    res_next.end_addr   = {page_reg + HI_W'(1), {dprt_pkg::PAGE_SH{1'b0}}};
                    res_next.last       = 1'b1;
                end
                state_next = dprt_pkg::S_IDLE;
            end
            dprt_pkg::S_FLUSH_LD:
            begin
                mem_we       = 1'b1;
                mem_wdata    = '0;
                sh_next      = rd_data_reg;
                j_next       = '0;
                in_run_next  = 1'b0;
                word_m1_next = word_addr_reg - dprt_pkg::ADDR_W'(1);
                state_next   = dprt_pkg::S_FLUSH_SCAN;
            end
            dprt_pkg::S_FLUSH_SCAN:
            begin
                sh_next = sh_reg >> 1;
                j_next  = j_reg + 5'd1;
                if (sh_reg == '0)
                begin
                    state_next = dprt_pkg::S_IDLE;
                end
                else if (sh_reg[0])
                begin
                    if (!in_run_reg)
                    begin
                        run_first_next = j_reg;
                        in_run_next    = 1'b1;
                    end
                    if (!sh_reg[1])
                    begin
                        // run ends at this bit
                        in_run_next         = 1'b0;
                        res_valid_next      = 1'b1;
                        res_next.kind       = dprt_pkg::KIND_RANGE;
                        res_next.first_addr = word_addr_reg
                            + (dprt_pkg::ADDR_W'(first_bit) << dprt_pkg::PAGE_SH);
                        res_next.end_addr   = word_m1_reg
                            + (dprt_pkg::ADDR_W'(run_end) << dprt_pkg::PAGE_SH);
                        res_next.last       = (sh_reg[dprt_pkg::BITS_W-1:2] == '0);
                        if (sh_reg[dprt_pkg::BITS_W-1:2] == '0)
                        begin
                            state_next = dprt_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = dprt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dprt_pkg::S_CLEAR;
            base_reg      <= '0;
            mcnt_reg      <= '0;
            in_run_reg    <= 1'b0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            mcnt_reg      <= mcnt_next;
            in_run_reg    <= in_run_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        bit_reg       <= bit_next;
        idx_reg       <= idx_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        word_addr_reg <= word_addr_next;
        word_m1_reg   <= word_m1_next;
        sh_reg        <= sh_next;
        j_reg         <= j_next;
        run_first_reg <= run_first_next;
        res_reg       <= res_next;
    end

    // bitmap ram
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ($past(state_reg) == dprt_pkg::S_MARK_WR
                        || $past(state_reg) == dprt_pkg::S_FLUSH_SCAN))
        else $error("result beat outside mark write or flush scan");

    a_window_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == dprt_pkg::KIND_WINDOW
            |-> res_reg.last && res_reg.end_addr == res_reg.first_addr + 48'd4096)
        else $error("write window beat malformed");

    a_range_align: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == dprt_pkg::KIND_RANGE
            |-> res_reg.first_addr[11:0] == 12'h000 && res_reg.end_addr[11:0] == 12'hFFF)
        else $error("flush range not page aligned");

    a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("bitmap read and write collide on one word");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == dprt_pkg::S_CLEAR && state_reg != dprt_pkg::S_CLEAR
            |-> state_reg == dprt_pkg::S_IDLE && !res_valid_reg)
        else $error("clearing sweep left to a state other than idle");
`endif

endmodule

// ----- verif/dirty_page_range_tracker_core_tb.sv -----
// self-checking regression testbench for the dirty page range tracker core
`timescale 1ns / 1ps

module dirty_page_range_tracker_core_tb;

    localparam int ADDR_W        = dprt_pkg::ADDR_W;
    localparam int WIDX_W        = dprt_pkg::WIDX_W;
    localparam int BITS_W        = dprt_pkg::BITS_W;
    localparam int PAGE_SH       = dprt_pkg::PAGE_SH;
    localparam int WORD_SH       = dprt_pkg::WORD_SH;
    localparam int NUM_WORDS     = 128;
    localparam int PAGE_BYTES    = 4096;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 200000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    dprt_pkg::req_t    request;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_data;
    logic              result_valid;
    dprt_pkg::res_t    result;

    logic [BITS_W-1:0] shadow_bitmap [NUM_WORDS];
    logic [ADDR_W-1:0] shadow_base;
    dprt_pkg::res_t    pending_beats [$];
    int                errors;
    int                items_sent;
    int                idle_pct;
    int                cycles = 0;

    dirty_page_range_tracker_core #(
        .PAGE_WORDS(NUM_WORDS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .result_valid(result_valid),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic dprt_pkg::req_t make_request(input logic cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [WIDX_W-1:0] widx);
        dprt_pkg::req_t r;
        r.command     = cmd;
        r.target_addr = addr;
        r.word_index  = widx;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic void apply_command(input dprt_pkg::req_t r);
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] page;
        logic [ADDR_W-1:0] word_addr;
        logic [BITS_W-1:0] map;
        int                w;
        int                b;
        int                j;
        int                run_lo;
        dprt_pkg::res_t    beat;
        if (r.command == dprt_pkg::CMD_MARK)
        begin
            offset = r.target_addr - shadow_base;
            w      = offset[WORD_SH +: WIDX_W];
            b      = offset[PAGE_SH +: 5];
            if (!shadow_bitmap[w][b])
            begin
                page            = {r.target_addr[ADDR_W-1:PAGE_SH], 12'h000};
                beat.kind       = dprt_pkg::KIND_WINDOW;
                beat.first_addr = page;
                beat.end_addr   = page + ADDR_W'(PAGE_BYTES);
                beat.last       = 1'b1;
                pending_beats.push_back(beat);
                shadow_bitmap[w][b] = 1'b1;
            end
        end
        else if (r.word_index < NUM_WORDS)
        begin
            map       = shadow_bitmap[r.word_index];
            word_addr = shadow_base + (ADDR_W'(r.word_index) << WORD_SH);
            j         = 0;
            while (j < BITS_W)
            begin
                if (map[j])
                begin
                    run_lo = j;
                    while (j < BITS_W && map[j])
                        j++;
                    beat.kind       = dprt_pkg::KIND_RANGE;
                    beat.first_addr = word_addr + ADDR_W'(run_lo * PAGE_BYTES);
                    beat.end_addr   = word_addr + ADDR_W'(j * PAGE_BYTES) - ADDR_W'(1);
                    beat.last       = ((map >> j) == '0);
                    pending_beats.push_back(beat);
                end
                else
                    j++;
            end
            shadow_bitmap[r.word_index] = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("[%0t] mismatch in %s: got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_command(input dprt_pkg::req_t r);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_command(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(negedge clk);
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cache_base(input logic [ADDR_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        shadow_base = {value[ADDR_W-1:PAGE_SH], 12'h000};
    endtask

    task automatic test_mark_windows();
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0000_0000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0000_0FFF, 7'd127));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'hFFFF_FFFF_FFFF, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0001_F000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0001_E000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0000_2000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0100_0002, 7'd0));
        wait_idle();
    endtask

    task automatic test_flush_ranges();
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'hFFFF_FFFF_FFFF, 7'd0));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd127));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd5));
        wait_idle();
    endtask

    task automatic test_base_extremes();
        write_cache_base(48'hFFFF_FFFF_F123);
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h0000_0000_0000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'hFFFF_FFFF_F800, 7'd0));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd0));
        wait_idle();
        write_cache_base(48'h8000_0000_0FFF);
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h7FFF_FFFF_FFFF, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h8000_0003_E000, 7'd0));
        send_command(make_request(dprt_pkg::CMD_MARK, 48'h8000_0003_F7FF, 7'd0));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd1));
        send_command(make_request(dprt_pkg::CMD_FLUSH, 48'h0000_0000_0000, 7'd127));
        wait_idle();
    endtask

    // mostly mark-then-flush sequences on one word, the rest random commands
    task automatic run_random_phase(input int sender_idle, input int quota);
        int                goal;
        int                w;
        int                b;
        int                len;
        logic [BITS_W-1:0] pattern;
        logic [ADDR_W-1:0] addr;
        idle_pct = sender_idle;
        goal     = items_sent + quota;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                w = $urandom_range(0, NUM_WORDS - 1);
                case ($urandom_range(0, 4))
                    0: pattern = $urandom & $urandom & $urandom;
                    1: pattern = $urandom;
                    2: pattern = $urandom_range(0, 1) ? 32'h5555_5555 : 32'hAAAA_AAAA;
                    3:
                    begin
                        len     = $urandom_range(1, BITS_W);
                        pattern = ~32'h0 << (BITS_W - len);
                    end
                    default: pattern = 32'h1 << $urandom_range(0, BITS_W - 1);
                endcase
                for (b = 0; b < BITS_W; b++)
                begin
                    if (pattern[b])
                    begin
                        addr = shadow_base + {24'($urandom), 7'(w), 5'(b), 12'($urandom)};
                        send_command(make_request(dprt_pkg::CMD_MARK, addr, 7'($urandom)));
                        if ($urandom_range(0, 9) == 0)
                            send_command(make_request(dprt_pkg::CMD_MARK, addr,
                                                      7'($urandom)));
                    end
                end
                send_command(make_request(dprt_pkg::CMD_FLUSH, random_addr(), 7'(w)));
            end
            else
                send_command(make_request(1'($urandom), random_addr(), 7'($urandom)));
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        write_cache_base(random_addr());
        run_random_phase(28, 50);
        write_cache_base(random_addr());
        run_random_phase(54, 50);
        write_cache_base('0);
        run_random_phase(0, 50);
    endtask

    always @(posedge clk)
    begin
        dprt_pkg::res_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_beats.size() == 0)
                report_mismatch("unexpected beat", result.first_addr, '0);
            else
            begin
                want = pending_beats.pop_front();
                if (result.kind !== want.kind)
                    report_mismatch("kind", result.kind, want.kind);
                if (result.first_addr !== want.first_addr)
                    report_mismatch("first_addr", result.first_addr, want.first_addr);
                if (result.end_addr !== want.end_addr)
                    report_mismatch("end_addr", result.end_addr, want.end_addr);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("dirty_page_range_tracker_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        items_sent  = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        shadow_base = '0;
        foreach (shadow_bitmap[i])
            shadow_bitmap[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (busy !== 1'b0)
            @(negedge clk);

        test_mark_windows();
        test_flush_ranges();
        test_base_extremes();
        test_random_traffic();

        if (errors == 0)
            $display("dirty_page_range_tracker_core regression: pass");
        else
            $display("dirty_page_range_tracker_core regression: fail");
        $finish;
    end

endmodule
